FILE: src/tdm_pkg.sv
// ----------------------------------------------------------------------------
// tdm_pkg
// Shared types and constants for the text decoration mask pixel generator.
// ----------------------------------------------------------------------------
package tdm_pkg;

  localparam int PIX_W  = 8;
  localparam int MODE_W = 3;
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 4;

  localparam logic [MODE_W-1:0] MODE_UNDERLINE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DOUBLE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DASHED    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FRAMED    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OVERLINE  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CROSSED   = 3'd5;

  localparam logic [1:0] REG_CELL_WIDTH     = 2'd0;
  localparam logic [1:0] REG_CELL_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_LINE_THICKNESS = 2'd2;
  localparam logic [1:0] REG_LINE_POSITION  = 2'd3;

  localparam logic [7:0] ALPHA_SET   = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR = 8'h00;

  typedef struct packed {
    logic [7:0] cell_width;
    logic [7:0] cell_height;
    logic [5:0] line_thickness;
    logic [7:0] line_position;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PIX_W-1:0]  pix_x;
    logic [PIX_W-1:0]  pix_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] tile_rows;
    logic       in_tile;
  } out_item_t;

endpackage

FILE: src/tdm_cfg_regs.sv
// ----------------------------------------------------------------------------
// tdm_cfg_regs
// APB register file: cell size and line metrics, with read back.
// ----------------------------------------------------------------------------
module tdm_cfg_regs
  import tdm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_width     <= 8'd8;
      cfg_r.cell_height    <= 8'd16;
      cfg_r.line_thickness <= 6'd1;
      cfg_r.line_position  <= 8'd2;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CELL_WIDTH:     cfg_r.cell_width     <= pwdata[7:0];
        REG_CELL_HEIGHT:    cfg_r.cell_height    <= pwdata[7:0];
        REG_LINE_THICKNESS: cfg_r.line_thickness <= pwdata[5:0];
        REG_LINE_POSITION:  cfg_r.line_position  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CELL_WIDTH:     prdata = {24'd0, cfg_r.cell_width};
      REG_CELL_HEIGHT:    prdata = {24'd0, cfg_r.cell_height};
      REG_LINE_THICKNESS: prdata = {26'd0, cfg_r.line_thickness};
      REG_LINE_POSITION:  prdata = {24'd0, cfg_r.line_position};
      default:            prdata = '0;
    endcase
  end

endmodule

FILE: src/tdm_mask.sv
// ----------------------------------------------------------------------------
// tdm_mask
// Per-pixel stroke geometry: tile height, in-tile test and mask value.
// ----------------------------------------------------------------------------
module tdm_mask
  import tdm_pkg::*;
(
  input  cfg_t      cfg,
  input  in_item_t  item,
  output out_item_t res
);

  logic [7:0] w, h, p, x, y;
  logic [5:0] tt;

  logic [6:0]  ul_sum;
  logic [5:0]  t_ul;
  logic [7:0]  dbl_num;
  logic [15:0] dbl_prod;
  logic [6:0]  t_db;
  logic [7:0]  t3_db;
  logic [7:0]  a_db, c_db;
  logic [8:0]  c_end;
  logic [6:0]  t_ds;
  logic [9:0]  d4, d2, dash_off;
  logic [4:0]  t_fr;

  logic       valid, set_px, hit_tile;
  logic [7:0] rows;

  assign w  = cfg.cell_width;
  assign h  = cfg.cell_height;
  assign p  = cfg.line_position;
  assign tt = cfg.line_thickness;
  assign x  = item.pix_x;
  assign y  = item.pix_y;

  always_comb begin
    ul_sum   = {1'b0, tt} + 7'd1;
    t_ul     = (ul_sum[6:1] == 6'd0) ? 6'd1 : ul_sum[6:1];

    // (2T+2)/3 by reciprocal, exact below 512
    dbl_num  = {1'b0, tt, 1'b0} + 8'd2;
    dbl_prod = 16'(dbl_num) * 16'd171;
    t_db     = (dbl_prod[15:9] == 7'd0) ? 7'd1 : dbl_prod[15:9];
    t3_db    = 8'({1'b0, t_db} + {t_db, 1'b0});
    a_db     = (p > {1'b0, t_db}) ? (p - {1'b0, t_db}) : 8'd0;
    c_db     = (a_db < t3_db) ? a_db : t3_db;
    c_end    = {1'b0, c_db} + {2'b0, t_db};

    t_ds     = {t_ul, 1'b0};
    d4       = {x, 2'b00};
    d2       = {1'b0, w, 1'b0};
    dash_off = (d4 >= d2) ? (d4 - d2) : (d2 - d4);

    t_fr     = (tt[5:1] == 5'd0) ? 5'd1 : tt[5:1];

    valid  = 1'b1;
    set_px = 1'b0;
    rows   = 8'd0;
    unique case (item.mode)
      MODE_UNDERLINE: begin
        rows   = (p > {2'b0, t_ul}) ? p : {2'b0, t_ul};
        set_px = y < {2'b0, t_ul};
      end
      MODE_DOUBLE: begin
        rows   = (p > {1'b0, t_db}) ? p : {1'b0, t_db};
        set_px = (y < {1'b0, t_db}) || ((y >= c_db) && ({1'b0, y} < c_end));
      end
      MODE_DASHED: begin
        rows   = (p > {1'b0, t_ds}) ? p : {1'b0, t_ds};
        set_px = (y < {1'b0, t_ds}) && (dash_off >= {2'b0, w});
      end
      MODE_FRAMED: begin
        rows   = h;
        set_px = (y < {3'b0, t_fr}) || (({1'b0, y} + {4'b0, t_fr}) >= {1'b0, h}) ||
                 (x < {3'b0, t_fr}) || (({1'b0, x} + {4'b0, t_fr}) >= {1'b0, w});
      end
      MODE_OVERLINE: begin
        rows   = h;
        set_px = y < {2'b0, tt};
      end
      MODE_CROSSED: begin
        rows   = {1'b0, h[7:1]};
        set_px = (y != 8'd0) && (y <= {2'b0, tt});
      end
      default: valid = 1'b0;
    endcase

    hit_tile      = valid && (x < w) && (y < rows);
    res.alpha     = (hit_tile && set_px) ? ALPHA_SET : ALPHA_CLEAR;
    res.tile_rows = rows;
    res.in_tile   = hit_tile;
  end

endmodule

FILE: src/text_decoration_mask_pixel.sv
// An accepted input beat is held in the input register; its result is then
// registered into the result register, which drives out_data.
// Throughput: one pixel per cycle while out_ready is high, set by the single
// input register to result register pass through the stroke geometry logic.
// Reset (rst_n low, synchronous): both pipeline stages empty, registers
// return to width 8, height 16, thickness 1, position 2.
// ----------------------------------------------------------------------------
// text_decoration_mask_pixel
// Two-stage pipeline around the decoration mask logic, with APB config.
// ----------------------------------------------------------------------------
module text_decoration_mask_pixel
  import tdm_pkg::*;
#(
  parameter int COORD_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int XB = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
  localparam logic [PIX_W-1:0] CoordMask = PIX_W'((1 << XB) - 1);

  cfg_t      cfg;
  in_item_t  s1_item_r, s1_masked;
  out_item_t s2_item_r, res_nxt;
  logic      s1_v_r, s2_v_r;
  logic      s1_take, s2_take;

  tdm_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    s1_masked       = s1_item_r;
    s1_masked.pix_x = s1_item_r.pix_x & CoordMask;
    s1_masked.pix_y = s1_item_r.pix_y & CoordMask;
  end

  tdm_mask u_mask (
    .cfg  (cfg),
    .item (s1_masked),
    .res  (res_nxt)
  );

  assign s2_take   = !s2_v_r || out_ready;
  assign s1_take   = !s1_v_r || s2_take;
  assign in_ready  = s1_take;
  assign out_valid = s2_v_r;
  assign out_data  = s2_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_take) s1_v_r <= in_valid;
      if (s2_take) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_take) s1_item_r <= in_data;
    if (s1_v_r && s2_take)   s2_item_r <= res_nxt;
  end

endmodule

FILE: src/tdm_checker.sv
// ----------------------------------------------------------------------------
// tdm_checker
// Port-level checks on the result channel of the mask pixel generator.
// ----------------------------------------------------------------------------
module tdm_checker
  import tdm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_alpha_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.alpha == ALPHA_SET || out_data.alpha == ALPHA_CLEAR))
    else $error("alpha neither clear nor set");

  a_alpha_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.alpha == ALPHA_SET |-> out_data.in_tile)
    else $error("mask set outside tile");

  a_tile_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.in_tile |-> out_data.tile_rows != 8'd0)
    else $error("in tile with empty tile");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind text_decoration_mask_pixel tdm_checker u_tdm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for text_decoration_mask_pixel. It writes the cell registers over
// the APB-style port and sends pixel beats for every decoration mode. A
// built-in predictor works out alpha, tile height and the in-tile flag for
// each accepted pixel. A checker compares every result beat with the oldest
// prediction. Both channels idle at random, and one long receiver hold-off
// fills the pipeline.
// ----------------------------------------------------------------------------
module tb;
  import tdm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // cell registers as the predictor sees them
  int unsigned cell_w, cell_h, stroke_t, stroke_pos;

  out_item_t   mask_expected[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  bit          sender_gappy = 1'b1;
  bit          hold_req = 1'b0;

  text_decoration_mask_pixel dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned floor_sub(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic out_item_t predict_mask(input in_item_t px);
    int unsigned x, y, t, a, b, rows, d4, d2, span;
    bit known, mark, in_cell;
    out_item_t r;
    x = px.pix_x;
    y = px.pix_y;
    known = 1'b1;
    mark = 1'b0;
    rows = 0;
    case (px.mode)
      MODE_UNDERLINE: begin
        t = (stroke_t + 1) / 2;
        if (t == 0) t = 1;
        rows = floor_sub(stroke_pos, t) + t;
        mark = y < t;
      end
      MODE_DOUBLE: begin
        t = (2 * stroke_t + 2) / 3;
        if (t == 0) t = 1;
        a = floor_sub(stroke_pos, t);
        b = floor_sub(a, 3 * t);
        rows = a + t;
        mark = (y < t) || (y >= a - b && y < a - b + t);
      end
      MODE_DASHED: begin
        t = (stroke_t + 1) / 2;
        if (t == 0) t = 1;
        t = 2 * t;
        d4 = 4 * x;
        d2 = 2 * cell_w;
        span = (d4 >= d2) ? d4 - d2 : d2 - d4;
        rows = floor_sub(stroke_pos, t) + t;
        mark = (y < t) && (span >= cell_w);
      end
      MODE_FRAMED: begin
        t = stroke_t / 2;
        if (t == 0) t = 1;
        rows = cell_h;
        mark = (y < t) || (y + t >= cell_h) || (x < t) || (x + t >= cell_w);
      end
      MODE_OVERLINE: begin
        rows = cell_h;
        mark = y < stroke_t;
      end
      MODE_CROSSED: begin
        rows = cell_h / 2;
        mark = (y >= 1) && (y <= stroke_t);
      end
      default: known = 1'b0;
    endcase
    rows = rows & 8'hFF;
    in_cell = known && (x < cell_w) && (y < rows);
    r.alpha = (in_cell && mark) ? ALPHA_SET : ALPHA_CLEAR;
    r.tile_rows = known ? rows[7:0] : 8'd0;
    r.in_tile = in_cell;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (mask_expected.size() == 0) begin
        report_mismatch("unexpected result beat", 32'(out_data), '0);
      end else begin
        want = mask_expected.pop_front();
        if (out_data.alpha !== want.alpha)
          report_mismatch("alpha", 32'(out_data.alpha), 32'(want.alpha));
        if (out_data.tile_rows !== want.tile_rows)
          report_mismatch("tile_rows", 32'(out_data.tile_rows), 32'(want.tile_rows));
        if (out_data.in_tile !== want.in_tile)
          report_mismatch("in_tile", 32'(out_data.in_tile), 32'(want.in_tile));
      end
    end
  end

  // receiver: random stall styles, plus a long hold-off on request
  initial begin : receiver
    int unsigned hold_left, style_left, stall_style;
    hold_left = 0;
    style_left = 0;
    stall_style = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          stall_style = $urandom_range(0, 2);
          style_left = $urandom_range(16, 80);
        end
        style_left--;
        case (stall_style)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_pixel(input in_item_t px);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mask_expected.push_back(predict_mask(px));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = sender_gappy ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mask_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input int unsigned value);
    logic [31:0] stored;
    case (idx)
      REG_CELL_WIDTH:     stored = value & 8'hFF;
      REG_CELL_HEIGHT:    stored = value & 8'hFF;
      REG_LINE_THICKNESS: stored = value & 6'h3F;
      default:            stored = value & 8'hFF;
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== stored) report_mismatch("register readback", prdata, stored);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CELL_WIDTH:     cell_w = stored;
      REG_CELL_HEIGHT:    cell_h = stored;
      REG_LINE_THICKNESS: stroke_t = stored;
      default:            stroke_pos = stored;
    endcase
  endtask

  task automatic apply_cell(input int unsigned w, input int unsigned h,
                            input int unsigned t, input int unsigned p);
    cfg_write(REG_CELL_WIDTH, w);
    cfg_write(REG_CELL_HEIGHT, h);
    cfg_write(REG_LINE_THICKNESS, t);
    cfg_write(REG_LINE_POSITION, p);
  endtask

  // mostly inside or just past the tile bound, sometimes anywhere
  function automatic logic [7:0] near_coord(input int unsigned bound);
    int unsigned top;
    top = (bound + 2 > 255) ? 255 : bound + 2;
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) return (bound > 255) ? 8'd255 : 8'(bound);
    return 8'($urandom_range(0, top));
  endfunction

  function automatic in_item_t random_pixel();
    in_item_t px;
    int unsigned ybound;
    if ($urandom_range(0, 9) == 0)
      px.mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    else px.mode = MODE_W'($urandom_range(MODE_UNDERLINE, MODE_CROSSED));
    ybound = (cell_h > stroke_pos) ? cell_h : stroke_pos;
    if (stroke_t + 1 > ybound) ybound = stroke_t + 1;
    px.pix_x = near_coord(cell_w);
    px.pix_y = near_coord(ybound);
    return px;
  endfunction

  function automatic int unsigned pick_reg(input int unsigned lo, input int unsigned hi);
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? lo : hi;
    return $urandom_range(lo, hi);
  endfunction

  task automatic test_reset_cell();
    in_item_t px;
    for (int m = 0; m < 8; m++) begin
      px.mode = MODE_W'(m);
      px.pix_x = 8'd0;
      px.pix_y = 8'd0;
      send_pixel(px);
      px.pix_x = 8'(cell_w - 1);
      px.pix_y = 8'd1;
      send_pixel(px);
      px.pix_x = 8'd255;
      px.pix_y = 8'd255;
      send_pixel(px);
    end
    wait_drain();
  endtask

  task automatic test_cell_extremes();
    int unsigned shapes[6][4] = '{
      '{1, 1, 0, 0}, '{255, 255, 63, 255}, '{0, 0, 63, 0},
      '{255, 16, 0, 255}, '{3, 255, 63, 5}, '{2, 8, 63, 1}
    };
    for (int s = 0; s < 6; s++) begin
      apply_cell(shapes[s][0], shapes[s][1], shapes[s][2], shapes[s][3]);
      for (int i = 0; i < 12; i++) send_pixel(random_pixel());
      wait_drain();
    end
  endtask

  task automatic test_pipeline_fill();
    sender_gappy = 1'b0;
    apply_cell(8, 16, 5, 9);
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_pixel(random_pixel());
    wait_drain();
    sender_gappy = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 25; ph++) begin
      apply_cell(pick_reg(1, 255), pick_reg(1, 255), pick_reg(0, 63), pick_reg(0, 255));
      sender_gappy = (ph % 3 != 2);
      for (int i = 0; i < 12; i++) send_pixel(random_pixel());
      wait_drain();
    end
    sender_gappy = 1'b1;
  endtask

  initial begin
    cell_w = 8;
    cell_h = 16;
    stroke_t = 1;
    stroke_pos = 2;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_cell();
    test_cell_extremes();
    test_pipeline_fill();
    test_random_traffic();
    repeat (10) @(posedge clk);
    if (mask_expected.size() != 0)
      report_mismatch("results never delivered", mask_expected.size(), 0);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/tdm_pkg.sv
src/tdm_cfg_regs.sv
src/tdm_mask.sv
src/text_decoration_mask_pixel.sv
src/tdm_checker.sv
test/tb.sv
